/* hw/rtl/lsi_pkg.sv */
`timescale 1ns / 1ps
// lsi_pkg: constants shared by the line/segment intersection pipeline
// no dependencies; used by lsi_div_pipe and line_segment_intersect

package lsi_pkg;

    // the two divider lanes: x and y of the meeting point
    localparam int LANES  = 2;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;

    // quotient bits beyond the coordinate width; anything larger saturates
    localparam int QUOT_GUARD = 2;

endpackage

/* hw/rtl/lsi_req_if.sv */
`timescale 1ns / 1ps
// lsi_req_if: request channel carrying two lines or segments
// no dependencies

interface lsi_req_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_origin_x;
    logic signed [COORD_WIDTH-1:0] first_origin_y;
    logic signed [COORD_WIDTH-1:0] first_dir_x;
    logic signed [COORD_WIDTH-1:0] first_dir_y;
    logic                          first_is_segment;
    logic signed [COORD_WIDTH-1:0] second_origin_x;
    logic signed [COORD_WIDTH-1:0] second_origin_y;
    logic signed [COORD_WIDTH-1:0] second_dir_x;
    logic signed [COORD_WIDTH-1:0] second_dir_y;
    logic                          second_is_segment;

    modport source (
        output valid, first_origin_x, first_origin_y, first_dir_x, first_dir_y,
               first_is_segment, second_origin_x, second_origin_y, second_dir_x,
               second_dir_y, second_is_segment,
        input  ready
    );

    modport sink (
        input  valid, first_origin_x, first_origin_y, first_dir_x, first_dir_y,
               first_is_segment, second_origin_x, second_origin_y, second_dir_x,
               second_dir_y, second_is_segment,
        output ready
    );
endinterface

/* hw/rtl/lsi_rsp_if.sv */
`timescale 1ns / 1ps
// lsi_rsp_if: response channel with hit flag and meeting point
// no dependencies

interface lsi_rsp_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] meet_x;
    logic signed [COORD_WIDTH-1:0] meet_y;

    modport source (
        output valid, hit, meet_x, meet_y,
        input  ready
    );

    modport sink (
        input  valid, hit, meet_x, meet_y,
        output ready
    );
endinterface

/* hw/rtl/line_segment_intersect.sv */
`timescale 1ns / 1ps
// throughput: one request per cycle unless the response stalls; the divider resolves one quotient bit per stage
// a stalled response holds its stage and bubbles ahead of it still fill
// reset clears the valid bit of every stage; data registers are not reset
// depends on lsi_pkg, lsi_req_if, lsi_rsp_if, lsi_div_pipe

module line_segment_intersect #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    lsi_req_if.sink   req,
    lsi_rsp_if.source rsp
);
    import lsi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int AW  = W + 1;          // origin difference
    localparam int DW  = 2 * W + 1;      // denominator
    localparam int PW  = 2 * W + 1;      // numerator products
    localparam int NW  = 2 * W + 2;      // numerators
    localparam int LOW = W + 1;          // low part of split numerator
    localparam int HIW = NW - LOW;       // high part of split numerator
    localparam int HPW = HIW + W;        // high partial product
    localparam int LPW = LOW + 1 + W;    // low partial product
    localparam int MW  = NW + W;         // full product n1*d1
    localparam int K   = W + QUOT_GUARD; // quotient bits
    localparam int RW  = K + 1;          // rounded quotient
    localparam int SW  = K + 2;          // point before saturation

    localparam int ST_DIV0  = 5;
    localparam int ST_DIVL  = ST_DIV0 + K - 1;
    localparam int ST_RND   = ST_DIV0 + K;
    localparam int ST_SUM   = ST_RND + 1;
    localparam int ST_OUT   = ST_SUM + 1;
    localparam int STAGES   = ST_OUT + 1;

    typedef struct packed {
        logic signed [W-1:0]  o1x;
        logic signed [W-1:0]  o1y;
        logic signed [W-1:0]  d1x;
        logic signed [W-1:0]  d1y;
        logic signed [W-1:0]  d2x;
        logic signed [W-1:0]  d2y;
        logic                 seg1;
        logic                 seg2;
        logic signed [AW-1:0] ax;
        logic signed [AW-1:0] ay;
    } s1_t;

    typedef struct packed {
        logic signed [W-1:0]   o1x;
        logic signed [W-1:0]   o1y;
        logic signed [W-1:0]   d1x;
        logic signed [W-1:0]   d1y;
        logic                  seg1;
        logic                  seg2;
        logic signed [2*W-1:0] pd_a;
        logic signed [2*W-1:0] pd_b;
        logic signed [PW-1:0]  pn1_a;
        logic signed [PW-1:0]  pn1_b;
        logic signed [PW-1:0]  pn2_a;
        logic signed [PW-1:0]  pn2_b;
    } s2_t;

    typedef struct packed {
        logic signed [W-1:0]  o1x;
        logic signed [W-1:0]  o1y;
        logic signed [W-1:0]  d1x;
        logic signed [W-1:0]  d1y;
        logic                 seg1;
        logic                 seg2;
        logic signed [DW-1:0] den;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
    } s3_t;

    typedef struct packed {
        logic signed [W-1:0]   o1x;
        logic signed [W-1:0]   o1y;
        logic                  hit;
        logic                  den_neg;
        logic [DW-1:0]         ud;
        logic signed [HPW-1:0] px_hi;
        logic signed [LPW-1:0] px_lo;
        logic signed [HPW-1:0] py_hi;
        logic signed [LPW-1:0] py_lo;
    } s4_t;

    typedef struct packed {
        logic signed [W-1:0]  o1x;
        logic signed [W-1:0]  o1y;
        logic                 hit;
        logic                 den_neg;
        logic [DW-1:0]        ud;
        logic signed [MW-1:0] numx;
        logic signed [MW-1:0] numy;
    } s5_t;

    // side data riding along the divider
    typedef struct packed {
        logic signed [W-1:0] o1x;
        logic signed [W-1:0] o1y;
        logic                hit;
        logic                negx;
        logic                negy;
        logic                ovfx;
        logic                ovfy;
    } side_t;

    typedef struct packed {
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic                 ovfx;
        logic                 ovfy;
        logic signed [W-1:0]  o1x;
        logic signed [W-1:0]  o1y;
        logic [RW-1:0]        qx;
        logic [RW-1:0]        qy;
    } rnd_t;

    typedef struct packed {
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic                 ovfx;
        logic                 ovfy;
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
    } sum_t;

    logic [STAGES-1:0] v_reg, v_next, en;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    s4_t   s4_reg, s4_next;
    s5_t   s5_reg, s5_next;
    side_t side_reg [K];
    side_t side_next;
    rnd_t  rnd_reg, rnd_next;
    sum_t  sum_reg, sum_next;

    logic                    hit_reg, hit_next;
    logic signed [W-1:0]     mx_reg, mx_next, my_reg, my_next;

    logic [DW-1:0]               div_ud_in, div_ud_out;
    logic [LANES-1:0][DW-1:0]    div_rem_in, div_rem_out;
    logic [LANES-1:0][K-1:0]     div_bits_in, div_quot_out;

    // stall chain: a stage moves when it is empty or the next stage moves
    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || rsp.ready;
        for (int i = STAGES - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
        for (int i = 0; i < STAGES; i++)
        begin
            if (!en[i])
                v_next[i] = v_reg[i];
            else if (i == 0)
                v_next[i] = req.valid;
            else
                v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign req.ready = en[0];
    assign rsp.valid = v_reg[STAGES-1];

    // stage 1: capture request, origin difference
    always_comb
    begin
        s1_next.o1x  = req.first_origin_x;
        s1_next.o1y  = req.first_origin_y;
        s1_next.d1x  = req.first_dir_x;
        s1_next.d1y  = req.first_dir_y;
        s1_next.d2x  = req.second_dir_x;
        s1_next.d2y  = req.second_dir_y;
        s1_next.seg1 = req.first_is_segment;
        s1_next.seg2 = req.second_is_segment;
        s1_next.ax   = $signed({req.second_origin_x[W-1], req.second_origin_x})
                     - $signed({req.first_origin_x[W-1], req.first_origin_x});
        s1_next.ay   = $signed({req.second_origin_y[W-1], req.second_origin_y})
                     - $signed({req.first_origin_y[W-1], req.first_origin_y});
    end

    // stage 2: cross product terms
    always_comb
    begin
        s2_next.o1x   = s1_reg.o1x;
        s2_next.o1y   = s1_reg.o1y;
        s2_next.d1x   = s1_reg.d1x;
        s2_next.d1y   = s1_reg.d1y;
        s2_next.seg1  = s1_reg.seg1;
        s2_next.seg2  = s1_reg.seg2;
        s2_next.pd_a  = $signed(s1_reg.d1x) * $signed(s1_reg.d2y);
        s2_next.pd_b  = $signed(s1_reg.d1y) * $signed(s1_reg.d2x);
        s2_next.pn1_a = $signed(s1_reg.ax) * $signed(s1_reg.d2y);
        s2_next.pn1_b = $signed(s1_reg.ay) * $signed(s1_reg.d2x);
        s2_next.pn2_a = $signed(s1_reg.ax) * $signed(s1_reg.d1y);
        s2_next.pn2_b = $signed(s1_reg.ay) * $signed(s1_reg.d1x);
    end

    // stage 3: denominator and both numerators
    always_comb
    begin
        s3_next.o1x  = s2_reg.o1x;
        s3_next.o1y  = s2_reg.o1y;
        s3_next.d1x  = s2_reg.d1x;
        s3_next.d1y  = s2_reg.d1y;
        s3_next.seg1 = s2_reg.seg1;
        s3_next.seg2 = s2_reg.seg2;
        s3_next.den  = $signed(s2_reg.pd_a) - $signed(s2_reg.pd_b);
        s3_next.n1   = $signed(s2_reg.pn1_a) - $signed(s2_reg.pn1_b);
        s3_next.n2   = $signed(s2_reg.pn2_a) - $signed(s2_reg.pn2_b);
    end

    // stage 4: hit decision, denominator magnitude, split products n1*d1
    always_comb
    begin
        logic signed [DW-1:0] den;
        logic signed [NW-1:0] n1, n2;
        logic                 neg, unit1, unit2;
        den = s3_reg.den;
        n1  = s3_reg.n1;
        n2  = s3_reg.n2;
        neg = den[DW-1];
        // parameter in [0,1] tested on the exact ratio
        if (neg)
        begin
            unit1 = (n1 <= 0) && (n1 >= den);
            unit2 = (n2 <= 0) && (n2 >= den);
        end
        else
        begin
            unit1 = (n1 >= 0) && (n1 <= den);
            unit2 = (n2 >= 0) && (n2 <= den);
        end
        s4_next.o1x     = s3_reg.o1x;
        s4_next.o1y     = s3_reg.o1y;
        s4_next.hit     = (den != 0) && (!s3_reg.seg1 || unit1) && (!s3_reg.seg2 || unit2);
        s4_next.den_neg = neg;
        s4_next.ud      = neg ? DW'(-den) : DW'(den);
        s4_next.px_hi   = $signed(n1[NW-1:LOW]) * $signed(s3_reg.d1x);
        s4_next.px_lo   = $signed({1'b0, n1[LOW-1:0]}) * $signed(s3_reg.d1x);
        s4_next.py_hi   = $signed(n1[NW-1:LOW]) * $signed(s3_reg.d1y);
        s4_next.py_lo   = $signed({1'b0, n1[LOW-1:0]}) * $signed(s3_reg.d1y);
    end

    // stage 5: join partial products
    always_comb
    begin
        s5_next.o1x     = s4_reg.o1x;
        s5_next.o1y     = s4_reg.o1y;
        s5_next.hit     = s4_reg.hit;
        s5_next.den_neg = s4_reg.den_neg;
        s5_next.ud      = s4_reg.ud;
        s5_next.numx    = $signed({s4_reg.px_hi, {LOW{1'b0}}}) + $signed(s4_reg.px_lo);
        s5_next.numy    = $signed({s4_reg.py_hi, {LOW{1'b0}}}) + $signed(s4_reg.py_lo);
    end

    // stage 6: magnitudes, quotient sign, overflow check, divider seed
    always_comb
    begin
        logic [MW-1:0] unx, uny;
        unx = s5_reg.numx[MW-1] ? MW'(-s5_reg.numx) : MW'(s5_reg.numx);
        uny = s5_reg.numy[MW-1] ? MW'(-s5_reg.numy) : MW'(s5_reg.numy);
        side_next.o1x  = s5_reg.o1x;
        side_next.o1y  = s5_reg.o1y;
        side_next.hit  = s5_reg.hit;
        side_next.negx = s5_reg.numx[MW-1] ^ s5_reg.den_neg;
        side_next.negy = s5_reg.numy[MW-1] ^ s5_reg.den_neg;
        side_next.ovfx = (DW'(unx[MW-1:K]) >= s5_reg.ud);
        side_next.ovfy = (DW'(uny[MW-1:K]) >= s5_reg.ud);
        div_ud_in              = s5_reg.ud;
        div_rem_in[LANE_X]     = DW'(unx[MW-1:K]);
        div_rem_in[LANE_Y]     = DW'(uny[MW-1:K]);
        div_bits_in[LANE_X]    = unx[K-1:0];
        div_bits_in[LANE_Y]    = uny[K-1:0];
    end

    lsi_div_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .clk      (clk),
        .en       (en[ST_DIVL:ST_DIV0]),
        .ud_in    (div_ud_in),
        .rem_in   (div_rem_in),
        .bits_in  (div_bits_in),
        .ud_out   (div_ud_out),
        .rem_out  (div_rem_out),
        .quot_out (div_quot_out)
    );

    // round to nearest, ties away from zero
    always_comb
    begin
        side_t sd;
        sd = side_reg[K-1];
        rnd_next.hit  = sd.hit;
        rnd_next.negx = sd.negx;
        rnd_next.negy = sd.negy;
        rnd_next.ovfx = sd.ovfx;
        rnd_next.ovfy = sd.ovfy;
        rnd_next.o1x  = sd.o1x;
        rnd_next.o1y  = sd.o1y;
        rnd_next.qx   = RW'(div_quot_out[LANE_X])
                      + RW'({div_rem_out[LANE_X], 1'b0} >= {1'b0, div_ud_out});
        rnd_next.qy   = RW'(div_quot_out[LANE_Y])
                      + RW'({div_rem_out[LANE_Y], 1'b0} >= {1'b0, div_ud_out});
    end

    // add the origin
    always_comb
    begin
        sum_next.hit  = rnd_reg.hit;
        sum_next.negx = rnd_reg.negx;
        sum_next.negy = rnd_reg.negy;
        sum_next.ovfx = rnd_reg.ovfx;
        sum_next.ovfy = rnd_reg.ovfy;
        if (rnd_reg.negx)
            sum_next.sx = $signed(rnd_reg.o1x) - $signed({1'b0, rnd_reg.qx});
        else
            sum_next.sx = $signed(rnd_reg.o1x) + $signed({1'b0, rnd_reg.qx});
        if (rnd_reg.negy)
            sum_next.sy = $signed(rnd_reg.o1y) - $signed({1'b0, rnd_reg.qy});
        else
            sum_next.sy = $signed(rnd_reg.o1y) + $signed({1'b0, rnd_reg.qy});
    end

    // saturate, zero on a miss
    always_comb
    begin
        logic [W-1:0] pos_max, neg_min;
        pos_max  = {1'b0, {(W-1){1'b1}}};
        neg_min  = {1'b1, {(W-1){1'b0}}};
        hit_next = sum_reg.hit;
        if (!sum_reg.hit)
            mx_next = '0;
        else if (sum_reg.ovfx)
            mx_next = sum_reg.negx ? neg_min : pos_max;
        else if (sum_reg.sx[SW-1:W-1] == '0 || sum_reg.sx[SW-1:W-1] == '1)
            mx_next = sum_reg.sx[W-1:0];
        else
            mx_next = sum_reg.sx[SW-1] ? neg_min : pos_max;
        if (!sum_reg.hit)
            my_next = '0;
        else if (sum_reg.ovfy)
            my_next = sum_reg.negy ? neg_min : pos_max;
        else if (sum_reg.sy[SW-1:W-1] == '0 || sum_reg.sy[SW-1:W-1] == '1)
            my_next = sum_reg.sy[W-1:0];
        else
            my_next = sum_reg.sy[SW-1] ? neg_min : pos_max;
    end

    // data registers of every stage
    always_ff @(posedge clk)
    begin
        if (en[0]) s1_reg <= s1_next;
        if (en[1]) s2_reg <= s2_next;
        if (en[2]) s3_reg <= s3_next;
        if (en[3]) s4_reg <= s4_next;
        if (en[4]) s5_reg <= s5_next;
        for (int k = 0; k < K; k++)
        begin
            if (en[ST_DIV0 + k])
                side_reg[k] <= (k == 0) ? side_next : side_reg[k-1];
        end
        if (en[ST_RND]) rnd_reg <= rnd_next;
        if (en[ST_SUM]) sum_reg <= sum_next;
        if (en[ST_OUT])
        begin
            hit_reg <= hit_next;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
        end
    end

    assign rsp.hit    = hit_reg;
    assign rsp.meet_x = mx_reg;
    assign rsp.meet_y = my_reg;

    // ready drops only when every stage holds a request
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (&v_reg))
        else $error("request refused with a free pipeline stage");

    // a hit never comes from a zero denominator
    a_hit_den: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && s4_reg.hit) |-> (s4_reg.ud != '0))
        else $error("hit with zero denominator");

    // x-lane divider remainder stays below the divisor for an in-range quotient
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_DIVL] && side_reg[K-1].hit && !side_reg[K-1].ovfx)
        |-> (div_rem_out[LANE_X] < div_ud_out))
        else $error("divider remainder out of range");

    // a miss reports a meeting point of zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_SUM] && en[ST_OUT] && !sum_reg.hit) |=> (mx_reg == '0 && my_reg == '0))
        else $error("miss with nonzero meeting point");

endmodule

/* hw/rtl/lsi_div_pipe.sv */
`timescale 1ns / 1ps
// lsi_div_pipe: pipelined restoring divider, one quotient bit per stage, x and y lanes
// depends on lsi_pkg

module lsi_div_pipe #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                                     clk,
    input  logic [COORD_WIDTH+lsi_pkg::QUOT_GUARD-1:0]               en,
    input  logic [2*COORD_WIDTH:0]                                   ud_in,
    input  logic [lsi_pkg::LANES-1:0][2*COORD_WIDTH:0]               rem_in,
    input  logic [lsi_pkg::LANES-1:0][COORD_WIDTH+lsi_pkg::QUOT_GUARD-1:0] bits_in,
    output logic [2*COORD_WIDTH:0]                                   ud_out,
    output logic [lsi_pkg::LANES-1:0][2*COORD_WIDTH:0]               rem_out,
    output logic [lsi_pkg::LANES-1:0][COORD_WIDTH+lsi_pkg::QUOT_GUARD-1:0] quot_out
);
    import lsi_pkg::*;

    localparam int K  = COORD_WIDTH + QUOT_GUARD;
    localparam int DW = 2 * COORD_WIDTH + 1;

    logic [DW-1:0]                ud_reg   [K];
    logic [LANES-1:0][DW-1:0]     rem_reg  [K];
    logic [LANES-1:0][DW-1:0]     rem_next [K];
    logic [LANES-1:0][K-1:0]      bits_reg [K];
    logic [LANES-1:0][K-1:0]      bits_next[K];

    // one compare and subtract per stage; dividend bits shift out as quotient bits shift in
    always_comb
    begin
        logic [DW-1:0]            ud_src;
        logic [LANES-1:0][DW-1:0] rem_src;
        logic [LANES-1:0][K-1:0]  bits_src;
        logic [DW:0]              trial;
        logic                     ge;
        for (int k = 0; k < K; k++)
        begin
            if (k == 0)
            begin
                ud_src   = ud_in;
                rem_src  = rem_in;
                bits_src = bits_in;
            end
            else
            begin
                ud_src   = ud_reg[k-1];
                rem_src  = rem_reg[k-1];
                bits_src = bits_reg[k-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_src[l], bits_src[l][K-1]};
                ge    = (trial >= {1'b0, ud_src});
                if (ge)
                    rem_next[k][l] = DW'(trial - {1'b0, ud_src});
                else
                    rem_next[k][l] = trial[DW-1:0];
                bits_next[k][l] = {bits_src[l][K-2:0], ge};
            end
        end
    end

    // stage registers, each held while its stage is stalled
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < K; k++)
        begin
            if (en[k])
            begin
                ud_reg[k]   <= (k == 0) ? ud_in : ud_reg[k-1];
                rem_reg[k]  <= rem_next[k];
                bits_reg[k] <= bits_next[k];
            end
        end
    end

    assign ud_out   = ud_reg[K-1];
    assign rem_out  = rem_reg[K-1];
    assign quot_out = bits_reg[K-1];

endmodule
